// File: hw/rtl/srfr_pkg.sv
// Shared types and constants for the sensor reply frame receiver.
// No dependencies; imported by every module of the block.
package srfr_pkg;

    localparam int unsigned MAX_PACKAGE_LENGTH = 128;

    localparam logic [7:0] HDR_START  = 8'hEF;
    localparam logic [7:0] HDR_SECOND = 8'h01;
    localparam logic [7:0] HDR_ADDR   = 8'hFF;

    // Byte positions within a frame, counted from 1.
    localparam logic [7:0] POS_HDR_LAST  = 8'd6;
    localparam logic [7:0] POS_PID       = 8'd7;
    localparam logic [7:0] POS_LEN_HIGH  = 8'd8;
    localparam logic [7:0] POS_LEN_LOW   = 8'd9;
    localparam logic [7:0] POS_CONFIRM   = 8'd10;
    localparam logic [7:0] POS_PARAM_0   = 8'd11;
    localparam logic [8:0] PARAM_END_OFS = 9'd7;
    localparam logic [8:0] CSUM_HI_OFS   = 9'd8;
    localparam logic [7:0] MIN_LEN       = 8'd3;
    localparam logic [7:0] MAX_LEN       = 8'(MAX_PACKAGE_LENGTH);
    localparam logic [7:0] MAX_POSITION  = 8'(MAX_PACKAGE_LENGTH + 9);

    typedef enum logic {
        KIND_PARAM  = 1'b0,
        KIND_FINISH = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [6:0]  index;
        logic        csum_ok;
        logic        len_err;
        logic [7:0]  plen;
    } t_result;

endpackage

// File: hw/rtl/sensor_reply_frame_receiver.sv
// Top level of the sensor reply frame receiver: input byte register,
// parser and output queue. Depends on srfr_pkg, srfr_parser, srfr_out_buf.

// Takes one received byte per transfer on the slave stream and checks the
// reply header EF 01 FF FF FF FF, dropping any mismatching byte. Each parameter
// byte comes out as a kind 0 result; the closing checksum byte, or a declared
// length that is nonzero in its high byte, below 3 or above 128, gives a kind 1
// result. Throughput is one byte per clock cycle, held as long as the master
// side takes results; a byte's result passes the input register, then the
// parser's single pass into the two-entry result queue, before it is offered
// on the master side. s_axis_tready is high while the input register is empty
// or the queue has room, so a byte is taken while a finished result still
// waits on the master side as long as the queue is not full.
module sensor_reply_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] data_byte, [14:8] param_index,
                                        // [15] checksum_ok, [16] length_error,
                                        // [24:17] package_length, rest zero
    output logic        m_axis_tuser    // [0] result_kind
);
    import srfr_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       can_take;
    logic       fire;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    assign fire          = r_in_valid && can_take;
    assign s_axis_tready = !r_in_valid || can_take;

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    srfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    srfr_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (res_valid),
        .i_res      (res),
        .o_can_take (can_take),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_res      (out_res)
    );

    assign m_axis_tdata = {7'd0, out_res.plen, out_res.len_err, out_res.csum_ok,
                           out_res.index, out_res.data};
    assign m_axis_tuser = out_res.kind;

endmodule

// File: hw/rtl/srfr_parser.sv
// Frame parser: header match, length check, running sum and result build.
// Depends on srfr_pkg. State advances on each processed byte.
module srfr_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    output logic             o_res_valid,
    output srfr_pkg::t_result o_res
);
    import srfr_pkg::*;

    logic [7:0]  r_byte_position, n_byte_position;
    logic [7:0]  r_len_high, n_len_high;
    logic [7:0]  r_decl_len, n_decl_len;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_confirm, n_confirm;
    logic [7:0]  r_csum_high, n_csum_high;

    logic [7:0]  pos;
    logic [8:0]  pos_w;
    logic [7:0]  want;
    logic [15:0] sum_add;
    logic [15:0] csum_got;
    logic [6:0]  param_ofs;

    assign pos       = r_byte_position + 8'd1;
    assign pos_w     = {1'b0, pos};
    assign sum_add   = r_sum + {8'd0, i_byte};
    assign csum_got  = {r_csum_high, i_byte};
    assign param_ofs = 7'(pos - POS_PARAM_0);

    always_comb begin
        want = HDR_ADDR;
        if (pos == 8'd1) begin
            want = HDR_START;
        end else if (pos == 8'd2) begin
            want = HDR_SECOND;
        end
    end

    always_comb begin
        n_byte_position = r_byte_position;
        n_len_high      = r_len_high;
        n_decl_len      = r_decl_len;
        n_sum           = r_sum;
        n_confirm       = r_confirm;
        n_csum_high     = r_csum_high;
        o_res_valid     = 1'b0;
        o_res           = '0;
        o_res.kind      = KIND_PARAM;
        o_res.plen      = r_decl_len;

        if (i_fire) begin
            if (pos <= POS_HDR_LAST) begin
                // mismatching byte is dropped, not retried as a frame start
                n_byte_position = (i_byte == want) ? pos : 8'd0;
            end else if (pos == POS_PID) begin
                n_sum           = {8'd0, i_byte};
                n_byte_position = pos;
            end else if (pos == POS_LEN_HIGH) begin
                n_len_high      = i_byte;
                n_sum           = sum_add;
                n_byte_position = pos;
            end else if (pos == POS_LEN_LOW) begin
                n_decl_len      = i_byte;
                n_sum           = sum_add;
                o_res.plen      = i_byte;
                if (r_len_high != 8'd0 || i_byte < MIN_LEN || i_byte > MAX_LEN) begin
                    o_res_valid     = 1'b1;
                    o_res.kind      = KIND_FINISH;
                    o_res.len_err   = 1'b1;
                    n_byte_position = 8'd0;
                end else begin
                    n_byte_position = pos;
                end
            end else if (pos == POS_CONFIRM) begin
                n_confirm       = i_byte;
                n_sum           = sum_add;
                n_byte_position = pos;
            end else if (pos_w <= PARAM_END_OFS + {1'b0, r_decl_len}) begin
                n_sum           = sum_add;
                n_byte_position = pos;
                o_res_valid     = 1'b1;
                o_res.data      = i_byte;
                o_res.index     = param_ofs;
            end else if (pos_w == CSUM_HI_OFS + {1'b0, r_decl_len}) begin
                n_csum_high     = i_byte;
                n_byte_position = pos;
            end else begin
                // closing checksum byte
                o_res_valid     = 1'b1;
                o_res.kind      = KIND_FINISH;
                o_res.data      = r_confirm;
                o_res.csum_ok   = (csum_got == r_sum);
                n_byte_position = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_position <= 8'd0;
            r_len_high      <= 8'd0;
            r_decl_len      <= 8'd0;
            r_sum           <= 16'd0;
            r_confirm       <= 8'd0;
            r_csum_high     <= 8'd0;
        end else begin
            r_byte_position <= n_byte_position;
            r_len_high      <= n_len_high;
            r_decl_len      <= n_decl_len;
            r_sum           <= n_sum;
            r_confirm       <= n_confirm;
            r_csum_high     <= n_csum_high;
        end
    end

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_position <= MAX_POSITION)
        else $error("frame position past longest frame");

    a_finish_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res_valid && o_res.kind == KIND_FINISH) |=> (r_byte_position == 8'd0))
        else $error("frame not restarted after finish");

    a_param_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_PARAM) |->
        (r_byte_position >= POS_CONFIRM && !o_res.len_err && !o_res.csum_ok))
        else $error("parameter byte outside payload");

    a_len_err_at_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.len_err) |-> (pos == POS_LEN_LOW))
        else $error("length error away from length byte");
`endif

endmodule

// File: hw/rtl/srfr_out_buf.sv
// Two-entry result queue in front of the output stream.
// Depends on srfr_pkg for the result type.
module srfr_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  srfr_pkg::t_result i_res,
    output logic              o_can_take,
    output logic              o_valid,
    input  logic              i_ready,
    output srfr_pkg::t_result o_res
);
    import srfr_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       wr_en;
    logic       rd_en;

    assign o_can_take = (r_count != 2'd2);
    assign o_valid    = (r_count != 2'd0);
    assign o_res      = r_mem[r_rd_ptr];
    assign wr_en      = i_valid && o_can_take;
    assign rd_en      = o_valid && i_ready;

    always_comb begin
        n_count = r_count;
        if (wr_en && !rd_en) begin
            n_count = r_count + 2'd1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("result queue overfilled");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) == (r_wr_ptr != r_rd_ptr))
        else $error("queue pointers disagree with count");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_can_take) |-> 1'b0)
        else $error("result offered to full queue");
`endif

endmodule
